// ===== rtl/software_timer_table_defines.svh =====
`ifndef SOFTWARE_TIMER_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define STT_ASSERT_NOW(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define STT_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stt_pkg.sv =====
package stt_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int ID_BITS    = 16;

  localparam int IDX_W   = $clog2(MAX_TIMERS);
  localparam int CNT_W   = $clog2(MAX_TIMERS + 1);
  localparam int COUNT_W = 28;
  localparam int TPS_W   = 16;
  localparam int SEC_W   = 12;
  localparam int ACT_W   = 8;
  localparam int TASK_W  = 16;
  localparam int RID_W   = 16;
  localparam int CMP_W   = (ID_BITS > TASK_W) ? ID_BITS : TASK_W;

  localparam logic [TPS_W-1:0] TPS_RESET = 16'd60;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_ADD_ONESHOT,
    CMD_ADD_PERIODIC,
    CMD_REMOVE
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_FIRED,
    KIND_CREATED,
    KIND_REMOVED,
    KIND_FULL
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_WALK,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [ID_BITS-1:0] ident;
    logic [COUNT_W-1:0] reload;
    logic [COUNT_W-1:0] remaining;
    logic               periodic;
    logic [ACT_W-1:0]   action;
  } entry_t;

  typedef struct packed {
    kind_t            kind;
    logic [RID_W-1:0] id;
    logic [ACT_W-1:0] action;
    logic             found;
  } result_t;

  // what the entry unit decided for the entry it looked at
  typedef struct packed {
    logic keep;
    logic fire;
    logic match;
  } verdict_t;

  function automatic logic [RID_W-1:0] id_to_result(input logic [ID_BITS-1:0] ident);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(ident);
    return wide[RID_W-1:0];
  endfunction

  function automatic logic id_match(input logic [ID_BITS-1:0] ident,
                                    input logic [TASK_W-1:0] tid);
    return CMP_W'(ident) == CMP_W'(tid);
  endfunction

endpackage

// ===== rtl/software_timer_table.sv =====
// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------------------
// input     | in_valid / in_stall        | command, seconds, action_code, task_id
// output    | out_valid / out_stall      | kind, result_id, fired_action, found, last
// config    | psel penable pwrite pready | paddr, pwdata, prdata
//
// add: accept, then multiply and table write, then result post
// tick and remove: one entry per cycle unless the walk is held (an empty-table tick goes straight back to idle)
// a firing with a result already pending and the output register stalled holds the walk
// in_stall stays high from acceptance until the last result, if any, sits in the output register
// reset empties the table, restarts ids at zero and sets ticks_per_second to 60; the ram is
// not cleared, only entries below entry_count are read
`include "software_timer_table_defines.svh"

module software_timer_table
  import stt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic [SEC_W-1:0]  seconds,
  input  logic [ACT_W-1:0]  action_code,
  input  logic [TASK_W-1:0] task_id,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic [RID_W-1:0]  result_id,
  output logic [ACT_W-1:0]  fired_action,
  output logic              found,
  output logic              last,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic REG_TPS = 1'b0;
  localparam int   EW      = $bits(entry_t);

  state_t            state, state_next;
  cmd_t              cmd_r;
  logic [SEC_W-1:0]  sec_r;
  logic [ACT_W-1:0]  act_r;
  logic [TASK_W-1:0] tid_r;
  logic [TPS_W-1:0]  tps;

  logic [CNT_W-1:0]   entry_count;
  logic [ID_BITS-1:0] next_id;
  logic [CNT_W-1:0]   rd_ptr, wr_ptr;
  logic [CNT_W-1:0]   rd_succ, wr_succ;

  result_t pend;
  logic    pend_valid;
  result_t out_r;
  logic    out_last;

  logic    in_accept, cfg_write, out_free, full, walk_go, walk_end;
  logic    out_load, load_last;
  result_t fired_res;

  logic [COUNT_W-1:0] sec_ext, tps_ext, add_count;
  entry_t             new_entry, ent_in, ent_out;
  verdict_t           verdict;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0]    ram_wdata, ram_rdata;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_TPS) ? 32'(tps) : 32'd0;

  // ---------------------------------------------------------------- datapath
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign full      = (entry_count == CNT_W'(MAX_TIMERS));
  assign rd_succ   = rd_ptr + CNT_W'(1);
  assign wr_succ   = verdict.keep ? wr_ptr + CNT_W'(1) : wr_ptr;
  assign walk_end  = (rd_succ == entry_count);

  assign sec_ext   = COUNT_W'(sec_r);
  assign tps_ext   = COUNT_W'(tps);
  assign add_count = sec_ext * tps_ext;

  always_comb begin
    new_entry.ident     = next_id;
    new_entry.reload    = add_count;
    new_entry.remaining = add_count;
    new_entry.periodic  = (cmd_r == CMD_ADD_PERIODIC);
    new_entry.action    = act_r;
  end

  assign ent_in = entry_t'(ram_rdata);

  stt_entry_unit u_unit (
    .mode_remove (cmd_r == CMD_REMOVE),
    .hit_in      (pend.found),
    .task_id     (tid_r),
    .ent_in      (ent_in),
    .ent_out     (ent_out),
    .verdict     (verdict)
  );

  always_comb begin
    fired_res.kind   = KIND_FIRED;
    fired_res.id     = id_to_result(ent_in.ident);
    fired_res.action = ent_in.action;
    fired_res.found  = 1'b0;
  end

  // a firing with an earlier one still pending must push that one out first
  assign walk_go = !(verdict.fire && pend_valid && !out_free);

  stt_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = wr_ptr[IDX_W-1:0];
    ram_wdata  = EW'(ent_out);
    ram_re     = 1'b0;
    ram_raddr  = rd_succ[IDX_W-1:0];
    out_load   = 1'b0;
    load_last  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          unique case (cmd_t'(command))
            CMD_ADD_ONESHOT, CMD_ADD_PERIODIC: begin
              state_next = S_ADD;
            end
            CMD_REMOVE: begin
              state_next = (entry_count == '0) ? S_FLUSH : S_WALK;
            end
            CMD_TICK: begin
              state_next = (entry_count == '0) ? S_IDLE : S_WALK;
            end
            default: ;
          endcase
          ram_re    = (entry_count != '0);
          ram_raddr = '0;
        end
      end
      S_ADD: begin
        ram_we     = !full;
        ram_waddr  = entry_count[IDX_W-1:0];
        ram_wdata  = EW'(new_entry);
        state_next = S_FLUSH;
      end
      S_WALK: begin
        if (walk_go) begin
          ram_we   = verdict.keep;
          ram_re   = !walk_end;
          out_load = verdict.fire && pend_valid;
          if (walk_end) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          load_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= cmd_t'(command);
      sec_r <= seconds;
      act_r <= action_code;
      tid_r <= task_id;
    end
    if (out_load) begin
      out_r    <= pend;
      out_last <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tps         <= TPS_RESET;
      entry_count <= '0;
      next_id     <= '0;
      rd_ptr      <= '0;
      wr_ptr      <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == REG_TPS) begin
        tps <= pwdata[TPS_W-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            rd_ptr      <= '0;
            wr_ptr      <= '0;
            pend_valid  <= (cmd_t'(command) == CMD_REMOVE);
            pend.kind   <= KIND_REMOVED;
            pend.id     <= task_id;
            pend.action <= '0;
            pend.found  <= 1'b0;
          end
        end
        S_ADD: begin
          pend_valid  <= 1'b1;
          pend.action <= '0;
          pend.found  <= 1'b0;
          if (full) begin
            pend.kind <= KIND_FULL;
            pend.id   <= '0;
          end else begin
            pend.kind   <= KIND_CREATED;
            pend.id     <= id_to_result(next_id);
            entry_count <= entry_count + CNT_W'(1);
            next_id     <= next_id + ID_BITS'(1);
          end
        end
        S_WALK: begin
          if (walk_go) begin
            rd_ptr <= rd_succ;
            wr_ptr <= wr_succ;
            if (verdict.match) begin
              pend.found <= 1'b1;
            end
            if (verdict.fire) begin
              pend       <= fired_res;
              pend_valid <= 1'b1;
            end
            if (walk_end) begin
              entry_count <= wr_succ;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid || out_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign kind         = out_r.kind;
  assign result_id    = out_r.id;
  assign fired_action = out_r.action;
  assign found        = out_r.found;
  assign last         = out_last;

  // ---------------------------------------------------------------- checks
  `STT_ASSERT_NOW(a_count_max, 1'b1, entry_count <= CNT_W'(MAX_TIMERS), "entry count above table size")
  `STT_ASSERT_NOW(a_walk_ptrs, state == S_WALK, (wr_ptr <= rd_ptr) && (rd_ptr < entry_count), "walk pointers out of order")
  `STT_ASSERT_NEXT(a_add_post, state == S_ADD, (state == S_FLUSH) && pend_valid, "add did not post its result")
  `STT_ASSERT_NOW(a_idle_clean, state == S_IDLE, !pend_valid, "pending result left behind in idle")

endmodule

// ===== rtl/stt_ram.sv =====
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/stt_entry_unit.sv =====
module stt_entry_unit
  import stt_pkg::*;
(
  input  logic              mode_remove,
  input  logic              hit_in,
  input  logic [TASK_W-1:0] task_id,
  input  entry_t            ent_in,
  output entry_t            ent_out,
  output verdict_t          verdict
);

  logic zero;

  always_comb begin
    zero    = (ent_in.remaining == '0);
    ent_out = ent_in;
    verdict = '0;
    if (mode_remove) begin
      // only the earliest matching entry goes
      verdict.match = !hit_in && id_match(ent_in.ident, task_id);
      verdict.keep  = !verdict.match;
    end else begin
      verdict.fire      = zero;
      verdict.keep      = !zero || ent_in.periodic;
      ent_out.remaining = zero ? ent_in.reload : ent_in.remaining - COUNT_W'(1);
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import stt_pkg::*;

  localparam logic [2:0] TPS_ADDR    = 3'd0;
  // byte address of register index 1, which the block does not have
  localparam logic [2:0] UNUSED_ADDR = 3'd4;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 43;

  typedef enum logic [2:0] {
    DRV_IDLE, DRV_GAP, DRV_SEND, DRV_DRAIN, DRV_SETTLE, DRV_SETUP, DRV_ACCESS
  } drv_state_t;

  typedef enum logic [1:0] {JOB_ITEM, JOB_PAUSE, JOB_WRITE} job_kind_t;

  typedef struct {
    job_kind_t         what;
    cmd_t              cmd;
    logic [SEC_W-1:0]  secs;
    logic [ACT_W-1:0]  act;
    logic [TASK_W-1:0] tid;
    logic              live;
    logic              quiet;
    logic [2:0]        addr;
    logic [31:0]       data;
  } job_t;

  typedef struct {
    logic [ID_BITS-1:0] ident;
    logic [COUNT_W-1:0] reload;
    logic [COUNT_W-1:0] remaining;
    logic               periodic;
    logic [ACT_W-1:0]   action;
  } timer_slot_t;

  typedef struct {
    kind_t            kind;
    logic [RID_W-1:0] id;
    logic [ACT_W-1:0] action;
    logic             found;
    logic             last;
  } timer_result_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        command = CMD_TICK;
  logic [SEC_W-1:0]  seconds = '0;
  logic [ACT_W-1:0]  action_code = '0;
  logic [TASK_W-1:0] task_id = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        kind;
  logic [RID_W-1:0]  result_id;
  logic [ACT_W-1:0]  fired_action;
  logic              found;
  logic              last;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  software_timer_table uut (
    .clk, .rst,
    .in_valid, .in_stall, .command, .seconds, .action_code, .task_id,
    .out_valid, .out_stall, .kind, .result_id, .fired_action, .found, .last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predicted block state
  timer_slot_t        slots [MAX_TIMERS];
  int                 slots_used = 0;
  logic [ID_BITS-1:0] id_next = '0;
  logic [TPS_W-1:0]   tps_model = TPS_RESET;

  job_t          jobs [$];
  timer_result_t pending_results [$];
  job_t          cur;
  drv_state_t    drv_state = DRV_IDLE;
  int            gap_left = 0;
  int            settle_left = 0;
  int            stall_left = 0;
  logic          calm = 1'b0;
  logic          fill_quiet = 1'b0;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int fired_seen = 0;
  int created_seen = 0;
  int removes_seen = 0;
  int removes_hit = 0;
  int full_seen = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_gap();
    if (calm) return 0;
    return $urandom_range(0, 4);
  endfunction

  function automatic void drop_slot(input int idx);
    for (int j = idx; j + 1 < slots_used; j++) slots[j] = slots[j + 1];
    slots_used--;
  endfunction

  task automatic predict_timer_results(input cmd_t cmd, input logic [SEC_W-1:0] secs,
                                       input logic [ACT_W-1:0] act,
                                       input logic [TASK_W-1:0] tid);
    timer_result_t out_q [$];
    timer_result_t ev;
    int i;
    logic hit;
    logic [COUNT_W-1:0] cnt;
    hit = 1'b0;
    ev = '{KIND_FIRED, '0, '0, 1'b0, 1'b0};
    case (cmd)
      CMD_ADD_ONESHOT, CMD_ADD_PERIODIC: begin
        if (slots_used == MAX_TIMERS) begin
          ev.kind = KIND_FULL;
          out_q.push_back(ev);
        end else begin
          cnt = COUNT_W'(32'(secs) * 32'(tps_model));
          slots[slots_used] = '{id_next, cnt, cnt, cmd == CMD_ADD_PERIODIC, act};
          slots_used++;
          ev.kind = KIND_CREATED;
          ev.id = RID_W'(id_next);
          out_q.push_back(ev);
          id_next++;
        end
      end
      CMD_REMOVE: begin
        // earliest match wins, the rest of the table closes up behind it
        for (i = 0; i < slots_used && !hit; i++) begin
          if (slots[i].ident == tid) begin
            drop_slot(i);
            hit = 1'b1;
          end
        end
        ev.kind = KIND_REMOVED;
        ev.id = tid;
        ev.found = hit;
        out_q.push_back(ev);
      end
      default: begin
        i = 0;
        while (i < slots_used) begin
          if (slots[i].remaining == '0) begin
            ev.kind = KIND_FIRED;
            ev.id = RID_W'(slots[i].ident);
            ev.action = slots[i].action;
            out_q.push_back(ev);
            if (slots[i].periodic) begin
              slots[i].remaining = slots[i].reload;
              i++;
            end else begin
              drop_slot(i);
            end
          end else begin
            slots[i].remaining--;
            i++;
          end
        end
      end
    endcase
    if (out_q.size() != 0) out_q[out_q.size() - 1].last = 1'b1;
    foreach (out_q[k]) pending_results.push_back(out_q[k]);
  endtask

  task automatic launch_item();
    // a remove aimed at a live timer picks its id from the current table
    if (cur.live && slots_used != 0) cur.tid = slots[$urandom_range(0, slots_used - 1)].ident;
    command <= cur.cmd;
    seconds <= cur.secs;
    action_code <= cur.act;
    task_id <= cur.tid;
    in_valid <= 1'b1;
    drv_state = DRV_SEND;
  endtask

  task automatic take_next();
    if (jobs.size() == 0) begin
      in_valid <= 1'b0;
      drv_state = DRV_IDLE;
    end else begin
      cur = jobs.pop_front();
      calm = cur.quiet;
      if (cur.what == JOB_ITEM) begin
        gap_left = pick_gap();
        if (gap_left == 0) begin
          launch_item();
        end else begin
          in_valid <= 1'b0;
          drv_state = DRV_GAP;
        end
      end else begin
        in_valid <= 1'b0;
        drv_state = DRV_DRAIN;
      end
    end
  endtask

  always @(posedge clk) begin : driver
    if (rst) begin
      in_valid <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      drv_state = DRV_IDLE;
    end else begin
      case (drv_state)
        DRV_IDLE: begin
          take_next();
        end
        DRV_GAP: begin
          if (gap_left > 1) gap_left--;
          else launch_item();
        end
        DRV_SEND: begin
          if (!in_stall) begin
            items_sent++;
            predict_timer_results(cur.cmd, cur.secs, cur.act, cur.tid);
            take_next();
          end
        end
        DRV_DRAIN: begin
          if (pending_results.size() == 0) begin
            settle_left = SETTLE_CYCLES;
            drv_state = DRV_SETTLE;
          end
        end
        DRV_SETTLE: begin
          // a tick that fires nothing may still be walking the table
          if (settle_left > 1) begin
            settle_left--;
          end else if (cur.what == JOB_WRITE) begin
            psel <= 1'b1;
            pwrite <= 1'b1;
            penable <= 1'b0;
            paddr <= cur.addr;
            pwdata <= cur.data;
            drv_state = DRV_SETUP;
          end else begin
            take_next();
          end
        end
        DRV_SETUP: begin
          penable <= 1'b1;
          drv_state = DRV_ACCESS;
        end
        DRV_ACCESS: begin
          if (pready) begin
            if (cur.addr == TPS_ADDR) tps_model = cur.data[TPS_W-1:0];
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            take_next();
          end
        end
        default: drv_state = DRV_IDLE;
      endcase
    end
  end

  always @(posedge clk) begin : monitor
    timer_result_t want;
    int pause_len;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: unexpected transaction kind %0d id %h act %h found %b last %b",
                   kind, result_id, fired_action, found, last);
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind || result_id !== want.id || fired_action !== want.action ||
            found !== want.found || last !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("tb: mismatch, expected kind %0d id %h act %h found %b last %b",
                     want.kind, want.id, want.action, want.found, want.last);
            $display("tb:           got kind %0d id %h act %h found %b last %b",
                     kind, result_id, fired_action, found, last);
          end
        end
        case (want.kind)
          KIND_FIRED:   fired_seen++;
          KIND_CREATED: created_seen++;
          KIND_REMOVED: begin
            removes_seen++;
            if (want.found) removes_hit++;
          end
          default:      full_seen++;
        endcase
      end
      pause_len = pick_gap();
      stall_left <= pause_len;
      out_stall <= (pause_len != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  task automatic queue_cmd(input cmd_t cmd, input logic [SEC_W-1:0] secs,
                           input logic [ACT_W-1:0] act, input logic [TASK_W-1:0] tid,
                           input logic live);
    jobs.push_back('{JOB_ITEM, cmd, secs, act, tid, live, fill_quiet, 3'd0, 32'd0});
  endtask

  task automatic queue_pause();
    jobs.push_back('{JOB_PAUSE, CMD_TICK, '0, '0, '0, 1'b0, fill_quiet, 3'd0, 32'd0});
  endtask

  task automatic queue_write(input logic [2:0] addr, input logic [31:0] data);
    jobs.push_back('{JOB_WRITE, CMD_TICK, '0, '0, '0, 1'b0, fill_quiet, addr, data});
  endtask

  task automatic queue_random_cmd();
    int r;
    logic [SEC_W-1:0] secs;
    r = $urandom_range(0, 99);
    // short lengths so that timers actually fire at the low rates
    secs = ($urandom_range(0, 6) == 0) ? SEC_W'($urandom_range(0, 4095))
                                       : SEC_W'($urandom_range(0, 4));
    if (r < 35)
      queue_cmd(CMD_TICK, secs, ACT_W'($urandom), TASK_W'($urandom), 1'b0);
    else if (r < 65)
      queue_cmd($urandom_range(0, 1) ? CMD_ADD_PERIODIC : CMD_ADD_ONESHOT, secs,
                ACT_W'($urandom), TASK_W'($urandom), 1'b0);
    else if (r < 88)
      queue_cmd(CMD_REMOVE, secs, ACT_W'($urandom), TASK_W'($urandom), 1'b1);
    else
      queue_cmd(CMD_REMOVE, secs, ACT_W'($urandom), TASK_W'($urandom_range(0, 65535)),
                1'b0);
  endtask

  initial begin : stimulus
    logic [31:0] rate_plan [PHASES];
    rate_plan = '{32'd1, 32'd0, 32'd2, 32'hFFFF_FFFF, 32'd3, 32'd1, 32'd0};
    rate_plan[PHASES - 1] = $urandom_range(4, 300);

    // directed part at the reset rate
    queue_cmd(CMD_TICK, 12'd0, 8'd0, 16'd0, 1'b0);
    queue_cmd(CMD_REMOVE, 12'd0, 8'd0, 16'h0000, 1'b0);
    queue_cmd(CMD_ADD_ONESHOT, 12'd0, 8'hFF, 16'd0, 1'b0);
    queue_cmd(CMD_ADD_PERIODIC, 12'd0, 8'h00, 16'd0, 1'b0);
    queue_cmd(CMD_ADD_ONESHOT, 12'hFFF, 8'hA5, 16'hFFFF, 1'b0);
    queue_cmd(CMD_ADD_PERIODIC, 12'd1, 8'h5A, 16'd0, 1'b0);
    queue_cmd(CMD_TICK, 12'hFFF, 8'hFF, 16'hFFFF, 1'b0);
    queue_cmd(CMD_REMOVE, 12'd0, 8'd0, 16'd2, 1'b0);
    queue_cmd(CMD_REMOVE, 12'd0, 8'd0, 16'hFFFF, 1'b0);
    for (int k = 0; k < MAX_TIMERS - 2; k++)
      queue_cmd(CMD_ADD_ONESHOT, 12'd0, ACT_W'(k * 37 + 3), 16'd0, 1'b0);
    queue_cmd(CMD_ADD_ONESHOT, 12'd5, 8'h11, 16'd0, 1'b0);
    queue_cmd(CMD_ADD_PERIODIC, 12'd5, 8'h22, 16'd0, 1'b0);
    // full table, nearly every entry fires on this tick
    queue_cmd(CMD_TICK, 12'd0, 8'd0, 16'd0, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      fill_quiet = (p == 4);
      queue_write(TPS_ADDR, rate_plan[p]);
      if (p == 1) queue_write(UNUSED_ADDR, $urandom);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ((p == 2 && k == 20) || $urandom_range(0, 49) == 0) queue_pause();
        queue_random_cmd();
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (jobs.size() != 0 || drv_state != DRV_IDLE || pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("tb: %0d results never arrived", pending_results.size());
      errors += pending_results.size();
    end

    $display("tb: %0d commands over %0d rate settings, %0d results checked, %0d mismatches",
             items_sent, PHASES + 1, results_seen, errors);
    $display("tb: %0d firings, %0d creations, %0d of %0d removes matched, %0d full rejects",
             fired_seen, created_seen, removes_hit, removes_seen, full_seen);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
